### rtl/base64_decoder_core_assert.svh
// Assertion macros shared by the base64 decoder RTL.
// Expects clk and rst (synchronous, active high) in the including module.
`ifndef BASE64_DECODER_CORE_ASSERT_SVH
`define BASE64_DECODER_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Antecedent implies consequent in the same cycle.
`define B64D_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("b64d assertion failed");
// Antecedent implies consequent in the next cycle.
`define B64D_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("b64d assertion failed");
`else
`define B64D_ASSERT_SAME(label, ante, cons)
`define B64D_ASSERT_NEXT(label, ante, cons)
`endif
`endif

### rtl/b64d_pkg.sv
// Shared types, status codes and character classification for the
// base64 decoder. No dependencies.
package b64d_pkg;

  localparam logic [7:0] PAD_CHAR = 8'h3D;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_NO_PAD  = 2'd2
  } status_t;

  // One classified character as it travels from front to back.
  typedef struct packed {
    logic [5:0] sextet;
    logic       bad;
    logic       pad;
    logic       last;
  } item_t;

  // Map a raw character onto its alphabet value; anything else is bad.
  function automatic item_t classify(input logic [7:0] ch, input logic last);
    item_t it;
    it.sextet = 6'd0;
    it.bad    = 1'b0;
    it.pad    = (ch == PAD_CHAR);
    it.last   = last;
    if (ch >= 8'h41 && ch <= 8'h5A) begin
      it.sextet = 6'(ch - 8'h41);
    end else if (ch >= 8'h61 && ch <= 8'h7A) begin
      it.sextet = 6'(ch - 8'h61 + 8'd26);
    end else if (ch >= 8'h30 && ch <= 8'h39) begin
      it.sextet = 6'(ch - 8'h30 + 8'd52);
    end else if (ch == 8'h2B) begin
      it.sextet = 6'd62;
    end else if (ch == 8'h2F) begin
      it.sextet = 6'd63;
    end else begin
      it.bad = 1'b1;
    end
    return it;
  endfunction

endpackage

### rtl/base64_decoder_core.sv
// Top level of the base64 character-stream decoder.
// Instantiates b64d_front, b64d_queue and b64d_back; uses b64d_pkg.
//
// Usage: the input channel (in_valid / in_stall) carries one Base64
// character per request in symbol, with end_of_text set on the final
// character of a text. The output channel (out_valid / out_stall) returns
// exactly one result per character: byte_valid with data_byte when the
// character completes a decoded byte, status (ok, invalid character seen,
// missing padding at end) and end_of_data copied from end_of_text.
// Throughput is one character per cycle while the receiver does not stall.
// A result passes through the classify register of the front stage and an
// entry of the queue before it lands in the decode register.
// Reset (rst, synchronous) empties the front register, the queue and the
// result register and returns the group state to its start.
// When the receiver stalls, the result register holds; the queue keeps
// filling, and in_stall rises only once the queue and front are both full.
module base64_decoder_core #(
  parameter int QUEUE_DEPTH = 4  // queue entries, two or more
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] symbol,
  input  logic       end_of_text,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       byte_valid,
  output logic [7:0] data_byte,
  output logic [1:0] status,
  output logic       end_of_data
);

  // Front to queue.
  logic            push_valid;
  logic            push_stall;
  b64d_pkg::item_t push_item;
  // Queue to back.
  logic            head_valid;
  logic            head_stall;
  b64d_pkg::item_t head_item;

  // Classify each character and hold it for the queue.
  b64d_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .symbol      (symbol),
    .end_of_text (end_of_text),
    .push_valid  (push_valid),
    .push_stall  (push_stall),
    .push_item   (push_item)
  );

  // Decouple the front from output back-pressure.
  b64d_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_stall (push_stall),
    .push_item  (push_item),
    .pop_valid  (head_valid),
    .pop_stall  (head_stall),
    .pop_item   (head_item)
  );

  // Advance the group state and splice sextets into bytes.
  b64d_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head_stall  (head_stall),
    .head_item   (head_item),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .byte_valid  (byte_valid),
    .data_byte   (data_byte),
    .status      (status),
    .end_of_data (end_of_data)
  );

endmodule

### rtl/b64d_front.sv
// Input stage: takes a character a cycle unless stalled, classifies it
// and holds it until the queue takes it. Depends on b64d_pkg.
module b64d_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [7:0]      symbol,
  input  logic            end_of_text,
  output logic            push_valid,
  input  logic            push_stall,
  output b64d_pkg::item_t push_item
);

  logic            front_valid;
  logic            front_valid_next;
  b64d_pkg::item_t front_item;
  logic            accept;

  assign in_stall   = front_valid && push_stall;
  assign accept     = in_valid && !in_stall;
  assign push_valid = front_valid;
  assign push_item  = front_item;

  always_comb begin
    front_valid_next = front_valid;
    if (accept) begin
      front_valid_next = 1'b1;
    end else if (front_valid && !push_stall) begin
      front_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front_valid <= 1'b0;
    end else begin
      front_valid <= front_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      front_item <= b64d_pkg::classify(symbol, end_of_text);
    end
  end

endmodule

### rtl/b64d_queue.sv
// Short queue of classified characters between front and back stages.
// Depends on b64d_pkg and base64_decoder_core_assert.svh.
`include "base64_decoder_core_assert.svh"
module b64d_queue #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_stall,
  input  b64d_pkg::item_t push_item,
  output logic            pop_valid,
  input  logic            pop_stall,
  output b64d_pkg::item_t pop_item
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  b64d_pkg::item_t  mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic [PTR_W-1:0] wr_ptr_next;
  logic [PTR_W-1:0] rd_ptr_next;
  logic [CNT_W-1:0] count_next;
  logic             push_fire;
  logic             pop_fire;

  assign push_stall = (count == CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_item   = mem[rd_ptr];
  assign push_fire  = push_valid && !push_stall;
  assign pop_fire   = pop_valid && !pop_stall;

  always_comb begin
    wr_ptr_next = wr_ptr;
    rd_ptr_next = rd_ptr;
    count_next  = count;
    if (push_fire) begin
      wr_ptr_next = (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
    end
    if (pop_fire) begin
      rd_ptr_next = (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
    end
    case ({push_fire, pop_fire})
      2'b10:   count_next = count + 1'b1;
      2'b01:   count_next = count - 1'b1;
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push_fire) begin
      mem[wr_ptr] <= push_item;
    end
  end

  `B64D_ASSERT_SAME(a_count_bound, 1'b1, count <= CNT_W'(DEPTH))
  `B64D_ASSERT_NEXT(a_wr_rd_gap, push_fire && !pop_fire && count == CNT_W'(DEPTH - 1),
                    wr_ptr == rd_ptr)

endmodule

### rtl/b64d_back.sv
// Decode stage: keeps group position, previous sextet and error flag,
// splices sextets into bytes and holds the result register.
// Depends on b64d_pkg and base64_decoder_core_assert.svh.
`include "base64_decoder_core_assert.svh"
module b64d_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             head_valid,
  output logic             head_stall,
  input  b64d_pkg::item_t  head_item,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             byte_valid,
  output logic [7:0]       data_byte,
  output logic [1:0]       status,
  output logic             end_of_data
);

  logic              pos_next_valid;
  logic [1:0]        pos;
  logic [5:0]        prev_sextet;
  logic              prev_bad;
  logic              error_seen;
  logic              pop_fire;
  logic              out_valid_next;
  logic              combine;
  logic              err_next;
  logic              emit;
  logic [1:0]        pos_inc;
  logic [7:0]        byte_next;
  b64d_pkg::status_t status_next;
  b64d_pkg::status_t out_status;

  assign head_stall = out_valid && out_stall;
  assign pop_fire   = head_valid && !head_stall;
  assign status     = out_status;

  always_comb begin
    combine  = (pos != 2'd0) && !head_item.pad && !error_seen;
    err_next = error_seen || (combine && (prev_bad || head_item.bad));
    emit     = combine && !prev_bad && !head_item.bad;
    pos_inc  = pos + 2'd1;
    pos_next_valid = (pos_inc != 2'd0);
    unique case (pos)
      2'd1:    byte_next = {prev_sextet, head_item.sextet[5:4]};
      2'd2:    byte_next = {prev_sextet[3:0], head_item.sextet[5:2]};
      2'd3:    byte_next = {prev_sextet[1:0], head_item.sextet};
      default: byte_next = 8'd0;
    endcase
    if (!emit) begin
      byte_next = 8'd0;
    end
    if (err_next) begin
      status_next = b64d_pkg::ST_INVALID;
    end else if (head_item.last && pos_next_valid) begin
      status_next = b64d_pkg::ST_NO_PAD;
    end else begin
      status_next = b64d_pkg::ST_OK;
    end
    out_valid_next = out_valid;
    if (pop_fire) begin
      out_valid_next = 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end
  end

  // Group state; the last character returns it to reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= 2'd0;
      prev_bad   <= 1'b1;
      error_seen <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
      if (pop_fire) begin
        if (head_item.last) begin
          pos        <= 2'd0;
          prev_bad   <= 1'b1;
          error_seen <= 1'b0;
        end else begin
          pos        <= pos_inc;
          prev_bad   <= head_item.bad;
          error_seen <= err_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop_fire) begin
      prev_sextet <= head_item.sextet;
      byte_valid  <= emit;
      data_byte   <= byte_next;
      out_status  <= status_next;
      end_of_data <= head_item.last;
    end
  end

  `B64D_ASSERT_NEXT(a_last_clears, pop_fire && head_item.last,
                    pos == 2'd0 && !error_seen)
  `B64D_ASSERT_SAME(a_byte_ok, out_valid && byte_valid,
                    out_status != b64d_pkg::ST_INVALID)

endmodule

### bench/tb_top.sv
// Self-checking bench for base64_decoder_core: directed table, then random Base64 texts.
// Carries its own character-level decoder as the predictor; needs b64d_pkg and the RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import b64d_pkg::*;

  localparam int CLK_HALF      = 2;
  localparam int RESET_CYCLES  = 9;
  localparam int RANDOM_ITEMS  = 1050;
  localparam int LONG_HOLD     = 40;
  localparam int TAIL_CYCLES   = 8;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int REPORT_LIMIT  = 10;
  localparam logic [6:0] NOT_IN_ALPHABET = 7'h40;

  // One result as the block returns it.
  typedef struct packed {
    logic       byte_valid;
    logic [7:0] data_byte;
    status_t    status;
    logic       end_of_data;
  } result_t;

  // A result typed into the directed table, where one is given.
  typedef struct packed {
    logic    known;
    result_t want;
  } stated_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    stated_t    stated;
  } drow_t;

  typedef enum int {
    TXT_CLEAN,
    TXT_CORRUPT,
    TXT_NOISE,
    TXT_TRUNCATED,
    TXT_STRAY_PAD
  } text_kind_t;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] symbol;
  logic       end_of_text;
  logic       out_valid;
  logic       out_stall;
  logic       byte_valid;
  logic [7:0] data_byte;
  logic [1:0] status;
  logic       end_of_data;

  base64_decoder_core u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .symbol      (symbol),
    .end_of_text (end_of_text),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .byte_valid  (byte_valid),
    .data_byte   (data_byte),
    .status      (status),
    .end_of_data (end_of_data)
  );

  // Directed requests. Rows with a stated result are checked against it;
  // the rest go through the predictor like the random part.
  localparam int N_DIRECTED = 25;
  drow_t directed_rows [N_DIRECTED] = '{
    // "TWFu" decodes to "Man"
    '{8'h54, 1'b0, '{1'b1, '{1'b0, 8'h00, ST_OK, 1'b0}}},
    '{8'h57, 1'b0, '{1'b1, '{1'b1, 8'h4D, ST_OK, 1'b0}}},
    '{8'h46, 1'b0, '{1'b1, '{1'b1, 8'h61, ST_OK, 1'b0}}},
    '{8'h75, 1'b1, '{1'b1, '{1'b1, 8'h6E, ST_OK, 1'b1}}},
    // "//+/": top of the alphabet at every position but the third, which has '+'
    '{8'h2F, 1'b0, '{1'b0, '0}},
    '{8'h2F, 1'b0, '{1'b0, '0}},
    '{8'h2B, 1'b0, '{1'b0, '0}},
    '{8'h2F, 1'b1, '{1'b0, '0}},
    // "QQ==": one byte, then two pad characters
    '{8'h51, 1'b0, '{1'b1, '{1'b0, 8'h00, ST_OK, 1'b0}}},
    '{8'h51, 1'b0, '{1'b1, '{1'b1, 8'h41, ST_OK, 1'b0}}},
    '{8'h3D, 1'b0, '{1'b1, '{1'b0, 8'h00, ST_OK, 1'b0}}},
    '{8'h3D, 1'b1, '{1'b1, '{1'b0, 8'h00, ST_OK, 1'b1}}},
    // "9z": group left open at the end, so padding is missing
    '{8'h39, 1'b0, '{1'b1, '{1'b0, 8'h00, ST_OK, 1'b0}}},
    '{8'h7A, 1'b1, '{1'b1, '{1'b1, 8'hF7, ST_NO_PAD, 1'b1}}},
    // 0xFF in the middle of a group: error sticks to the end of the text
    '{8'h41, 1'b0, '{1'b1, '{1'b0, 8'h00, ST_OK, 1'b0}}},
    '{8'hFF, 1'b0, '{1'b1, '{1'b0, 8'h00, ST_INVALID, 1'b0}}},
    '{8'h41, 1'b0, '{1'b1, '{1'b0, 8'h00, ST_INVALID, 1'b0}}},
    '{8'h41, 1'b1, '{1'b1, '{1'b0, 8'h00, ST_INVALID, 1'b1}}},
    // "Q=Q=": data after a stored pad combines with '=' and is rejected
    '{8'h51, 1'b0, '{1'b1, '{1'b0, 8'h00, ST_OK, 1'b0}}},
    '{8'h3D, 1'b0, '{1'b1, '{1'b0, 8'h00, ST_OK, 1'b0}}},
    '{8'h51, 1'b0, '{1'b1, '{1'b0, 8'h00, ST_INVALID, 1'b0}}},
    '{8'h3D, 1'b1, '{1'b1, '{1'b0, 8'h00, ST_INVALID, 1'b1}}},
    // single character text
    '{8'h41, 1'b1, '{1'b1, '{1'b0, 8'h00, ST_NO_PAD, 1'b1}}},
    // code 128 is stored quietly, then caught when the next one combines
    '{8'h80, 1'b0, '{1'b1, '{1'b0, 8'h00, ST_OK, 1'b0}}},
    '{8'h41, 1'b1, '{1'b1, '{1'b0, 8'h00, ST_INVALID, 1'b1}}}
  };

  // Predictor state: position in the group, previous character, sticky error.
  logic [1:0] grp_pos   = 2'd0;
  logic [7:0] prev_char = 8'h00;
  logic       err_seen  = 1'b0;

  result_t    pending_results [$];
  stated_t    stated_results  [$];
  logic [7:0] text_q          [$];

  int   items_sent    = 0;
  int   texts_sent    = 0;
  int   hold_requests = 0;
  int   mismatches    = 0;
  int   cycle_count   = 0;
  int   bytes_seen    = 0;
  int   invalid_seen  = 0;
  int   no_pad_seen   = 0;
  logic no_gaps       = 1'b0;
  logic burst         = 1'b0;

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Alphabet value in the low six bits; bit 6 set for anything outside it.
  function automatic logic [6:0] alphabet_value(input logic [7:0] ch);
    if (ch >= 8'h41 && ch <= 8'h5A) return {1'b0, 6'(ch - 8'h41)};
    if (ch >= 8'h61 && ch <= 8'h7A) return {1'b0, 6'(ch - 8'h61 + 8'd26)};
    if (ch >= 8'h30 && ch <= 8'h39) return {1'b0, 6'(ch - 8'h30 + 8'd52)};
    if (ch == 8'h2B) return 7'd62;
    if (ch == 8'h2F) return 7'd63;
    return NOT_IN_ALPHABET;
  endfunction

  // Inverse mapping, used to build well-formed texts.
  function automatic logic [7:0] alpha_char(input int unsigned v);
    if (v < 26) return 8'(v + 32'h41);
    if (v < 52) return 8'(v - 26 + 32'h61);
    if (v < 62) return 8'(v - 52 + 32'h30);
    return (v == 62) ? 8'h2B : 8'h2F;
  endfunction

  // Advance the predictor by one character and return its result.
  function automatic result_t decode_char(input logic [7:0] ch, input logic last);
    result_t    r;
    logic [6:0] a;
    logic [6:0] b;
    r = '{1'b0, 8'h00, ST_OK, last};
    // A pad, the first character of a group, or a text already in error
    // yields no byte and checks nothing.
    if (grp_pos != 2'd0 && ch != PAD_CHAR && !err_seen) begin
      a = alphabet_value(prev_char);
      b = alphabet_value(ch);
      if (a[6] || b[6]) begin
        err_seen = 1'b1;
      end else begin
        r.byte_valid = 1'b1;
        case (grp_pos)
          2'd1:    r.data_byte = {a[5:0], b[5:4]};
          2'd2:    r.data_byte = {a[3:0], b[5:2]};
          default: r.data_byte = {a[1:0], b[5:0]};
        endcase
      end
    end
    grp_pos   = grp_pos + 2'd1;
    prev_char = ch;
    if (err_seen) begin
      r.status = ST_INVALID;
    end else if (last && grp_pos != 2'd0) begin
      r.status = ST_NO_PAD;
    end
    // The end of a text returns everything to its start.
    if (last) begin
      grp_pos   = 2'd0;
      prev_char = 8'h00;
      err_seen  = 1'b0;
    end
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input result_t want, input result_t got);
    if (mismatches < REPORT_LIMIT) begin
      $display("[%0t] %s: want valid=%0b byte=%02h status=%0d end=%0b, got valid=%0b byte=%02h status=%0d end=%0b",
               $realtime, what, want.byte_valid, want.data_byte, want.status,
               want.end_of_data, got.byte_valid, got.data_byte, got.status,
               got.end_of_data);
    end
    mismatches++;
  endtask

  // Monitor. Sample both channels at the edge, before any of this edge's
  // updates land. Take the request side first so a result can never
  // overtake its own prediction.
  always @(posedge clk) begin
    result_t want;
    result_t got;
    stated_t stated;
    if (!rst && in_valid && !in_stall) begin
      want = decode_char(symbol, end_of_text);
      if (stated_results.size() != 0) begin
        stated = stated_results.pop_front();
        if (stated.known) want = stated.want;
      end
      pending_results.push_back(want);
    end
    if (!rst && out_valid && !out_stall) begin
      got = '{byte_valid, data_byte, status_t'(status), end_of_data};
      if (got.byte_valid === 1'b1) bytes_seen++;
      if (got.status == ST_INVALID) invalid_seen++;
      if (got.status == ST_NO_PAD) no_pad_seen++;
      if (pending_results.size() == 0) begin
        flag_mismatch("result with nothing pending", '0, got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) flag_mismatch("result mismatch", want, got);
      end
    end
  end

  // Watchdog: stop the run if it never finishes.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_results.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // Receiver. Draw a wait after every accepted result; now and then switch
  // to an eager spell with no stalls at all. A hold-off request from the
  // sender overrides everything with one long stall, counted here.
  initial begin : receiver
    int   hold_left;
    int   served;
    logic eager;
    hold_left = 0;
    served    = 0;
    eager     = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (served != hold_requests) begin
        served    = hold_requests;
        hold_left = LONG_HOLD;
      end else if (out_valid && !out_stall) begin
        if ($urandom_range(0, 39) == 0) eager = !eager;
        hold_left = eager ? 0 : $urandom_range(0, 6);
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Offer one request and return at the edge that accepts it. Valid stays
  // high on return, so a back-to-back request needs no extra assignment.
  task automatic offer(input logic [7:0] ch, input logic last, input stated_t stated);
    int gap;
    gap = (no_gaps || burst) ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    stated_results.push_back(stated);
    in_valid    <= 1'b1;
    symbol      <= ch;
    end_of_text <= last;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic send_text();
    foreach (text_q[i]) offer(text_q[i], i == text_q.size() - 1, '0);
    texts_sent++;
  endtask

  // Drop valid and hold until every predicted result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Build one random text. Most are well-formed groups with random content
  // and zero to two pads; the rest are corrupted, truncated, given a stray pad or plain noise.
  task automatic build_text();
    text_kind_t  kind;
    int unsigned pick;
    int          groups;
    int          pads;
    int          spot;
    text_q.delete();
    pick = $urandom_range(0, 9);
    kind = (pick < 6) ? TXT_CLEAN : text_kind_t'(pick - 5);
    if (kind == TXT_NOISE) begin
      repeat ($urandom_range(1, 8)) text_q.push_back(8'($urandom_range(0, 255)));
      return;
    end
    groups = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 3);
    repeat (4 * groups) text_q.push_back(alpha_char($urandom_range(0, 63)));
    pads = $urandom_range(0, 2);
    for (int k = 1; k <= pads; k++) text_q[text_q.size() - k] = PAD_CHAR;
    spot = $urandom_range(0, text_q.size() - 1);
    case (kind)
      TXT_CORRUPT:   text_q[spot] = 8'($urandom_range(0, 255));
      TXT_TRUNCATED: repeat ($urandom_range(1, 3)) void'(text_q.pop_back());
      TXT_STRAY_PAD: text_q[spot] = PAD_CHAR;
      default: ;
    endcase
  endtask

  initial begin : stimulus
    int texts;
    in_valid    <= 1'b0;
    symbol      <= 8'h00;
    end_of_text <= 1'b0;
    rst         <= 1'b1;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table first, then let it drain.
    foreach (directed_rows[i]) begin
      offer(directed_rows[i].ch, directed_rows[i].last, directed_rows[i].stated);
    end
    drain();

    texts = 0;
    while (items_sent < N_DIRECTED + RANDOM_ITEMS) begin
      if (texts == 15) begin
        // Long receiver hold-off with the sender at full rate: fill the
        // queue and push the stall back to the input.
        hold_requests++;
        no_gaps = 1'b1;
        text_q.delete();
        repeat (48) text_q.push_back(alpha_char($urandom_range(0, 63)));
        send_text();
        no_gaps = 1'b0;
      end else begin
        // Pause now and then until everything is back.
        if (texts % 60 == 30) drain();
        burst = ($urandom_range(0, 3) == 0);
        build_text();
        send_text();
      end
      texts++;
    end
    burst = 1'b0;

    // Wait for the last results, then give stray ones a chance to show.
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    mismatches += pending_results.size();

    $display("run: %0d requests in %0d texts (directed table plus random), %0d cycles",
             items_sent, texts_sent, cycle_count);
    $display("results: %0d decoded bytes, %0d invalid-character, %0d missing-padding, %0d mismatches",
             bytes_seen, invalid_seen, no_pad_seen, mismatches);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/b64d_pkg.sv
rtl/b64d_front.sv
rtl/b64d_queue.sv
rtl/b64d_back.sv
rtl/base64_decoder_core.sv
bench/tb_top.sv
